// ===== rtl/core/bsr_pkg.sv =====
// Shared types, widths and constants for the BC-spline image resampler.
// Holds the kernel coefficient function and the sequencer state encodings.
// No dependencies.
`default_nettype none
package bsr_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CHANNELS_DEF   = 4;
  localparam int CHN_MAX        = 4;
  localparam int TAP_RADIUS     = 2;
  localparam int TAPS           = 2 * TAP_RADIUS + 1;
  localparam int ONE_Q12        = 4096;

  // Datapath widths (signed unless noted)
  localparam int KW   = 26;  // kernel value, Q12
  localparam int TW   = 17;  // kernel distance below two, Q16, unsigned
  localparam int WW   = 36;  // tap weight, Q12
  localparam int WSW  = 41;  // weight sum
  localparam int CPW  = 45;  // channel times weight
  localparam int SW   = 50;  // channel sum
  localparam int MW   = 28;  // shared multiplier operand
  localparam int PRW  = 2 * MW;
  localparam int DVW  = 53;  // divider numerator
  localparam int DDW  = 42;  // divider denominator, unsigned

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_INV_SCALE_X = 3'd2,
    CFG_INV_SCALE_Y = 3'd3,
    CFG_COEF_B     = 3'd4,
    CFG_COEF_C     = 3'd5
  } bsr_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAPX, S_MAPY, S_MAPW, S_KSET, S_KMUL, S_KADD,
    S_TCHK, S_TWT, S_TCH, S_TACC, S_DIV, S_DSTART, S_DWAIT, S_OUT
  } bsr_state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_PREP, DV_ITER, DV_DONE
  } bsr_dv_state_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quo;
  } bsr_div_res_t;

  // Horner coefficient idx (3 cubic .. 0 constant) of the kernel, seg 1 for 1 <= t < 2
  function automatic logic signed [KW-1:0] kcoef(input logic signed [15:0] b,
                                                  input logic signed [15:0] c,
                                                  input logic seg,
                                                  input logic [1:0] idx);
    logic signed [KW-1:0] bb;
    logic signed [KW-1:0] cc;
    logic signed [KW-1:0] r;
    bb = KW'(b);
    cc = KW'(c);
    r  = '0;
    if (!seg) begin
      unique case (idx)
        2'd3: r = KW'(12 * ONE_Q12) - KW'(9 * bb) - KW'(6 * cc);
        2'd2: r = KW'(-18 * ONE_Q12) + KW'(12 * bb) + KW'(6 * cc);
        2'd1: r = '0;
        default: r = KW'(6 * ONE_Q12) - KW'(2 * bb);
      endcase
    end else begin
      unique case (idx)
        2'd3: r = -bb - KW'(6 * cc);
        2'd2: r = KW'(6 * bb) + KW'(30 * cc);
        2'd1: r = KW'(-12 * bb) - KW'(48 * cc);
        default: r = KW'(8 * bb) + KW'(24 * cc);
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bc_spline_image_resampler_top.sv =====
// A load item writes one pixel to the store in the cycle it is accepted. A compute item
// maps the coordinate, evaluates ten kernel values, visits each in-bounds tap of the
// 5x5 window and skips the others, then, unless the weight sum is zero, divides each
// channel in turn. One multiplier serves the coordinate mapping, the kernel polynomials
// and the tap weights, and the divider yields one quotient bit a cycle; together they
// set the pace of a compute item. in_tready is low for the whole computation; a
// finished result waits in the output register while the next item is taken.
`default_nettype none
module bc_spline_image_resampler_top #(
  parameter int MAX_WIDTH  = bsr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsr_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = bsr_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // col, row, chan_in_0, chan_in_1, chan_in_2, chan_in_3
  input  wire logic [0:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // chan_out_0, chan_out_1, chan_out_2, chan_out_3
  output logic [0:0]       out_tuser,  // empty_window
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import bsr_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = CHANNELS * 8;
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration
  logic [8:0]         width_r, height_r;
  logic [23:0]        isx_r, isy_r;
  logic signed [15:0] cb_r, cc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      isx_r    <= 24'd65536;
      isy_r    <= 24'd65536;
      cb_r     <= 16'sd1365;
      cc_r     <= 16'sd1365;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:   width_r  <= cfg_data[8:0];
        CFG_SRC_HEIGHT:  height_r <= cfg_data[8:0];
        CFG_INV_SCALE_X: isx_r    <= cfg_data;
        CFG_INV_SCALE_Y: isy_r    <= cfg_data;
        CFG_COEF_B:      cb_r     <= $signed(cfg_data[15:0]);
        CFG_COEF_C:      cc_r     <= $signed(cfg_data[15:0]);
        default: begin
        end
      endcase
    end
  end

  // Sequencer and datapath registers
  bsr_state_t              state_r, state_nxt;
  logic [11:0]             col_r, row_r;
  logic [35:0]             sx_r, sy_r;
  logic                    axis_r;
  logic [2:0]              tap_r;
  logic [1:0]              step_r;
  logic                    seg_r;
  logic [TW-1:0]           t_r;
  logic signed [KW-1:0]    p_r;
  logic signed [KW-1:0]    kx_r [TAPS];
  logic signed [KW-1:0]    ky_r [TAPS];
  logic [2:0]              ix_r, jy_r;
  logic signed [WW-1:0]    wt_r;
  logic [PW-1:0]           px_r;
  logic signed [CPW-1:0]   chp_r [CHANNELS];
  logic signed [SW-1:0]    sum_r [CHANNELS];
  logic signed [WSW-1:0]   wsum_r;
  logic [CHW-1:0]          ch_r;
  logic [7:0]              q_r [CHANNELS];
  logic                    out_valid_r;
  logic [31:0]             out_data_r;
  logic                    out_empty_r;

  // Shared units
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] prod;
  logic                  div_start;
  bsr_div_res_t          div_res;
  logic                  st_we;
  logic [AW-1:0]         st_waddr, st_raddr;
  logic [PW-1:0]         st_rdata;

  bsr_mul u_mul (
    .clk   (clk),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod_r(prod)
  );

  bsr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (sum_r[ch_r]),
    .den  (wsum_r),
    .res  (div_res)
  );

  bsr_store #(.DEPTH(DEPTH), .PW(PW)) u_store (
    .clk      (clk),
    .wr_en    (st_we),
    .wr_addr  (st_waddr),
    .wr_data  (in_tdata[24 +: PW]),
    .rd_addr  (st_raddr),
    .rd_data_r(st_rdata)
  );

  // Conditions
  logic               accept, load_ok, out_free, last_k, last_t, inb, kill;
  logic [15:0]        fr;
  logic signed [19:0] dlt;
  logic [17:0]        tcur;
  logic [12:0]        w_eff, h_eff;
  logic signed [21:0] xs, ys;
  logic signed [KW-1:0] hstep;

  always_comb begin
    accept  = in_tvalid && in_tready;
    load_ok = ({1'b0, in_tdata[11:0]} < 13'(MAX_WIDTH)) &&
              ({1'b0, in_tdata[23:12]} < 13'(MAX_HEIGHT));
    out_free = !out_valid_r || out_tready;
    last_k  = axis_r && (tap_r == 3'(TAPS - 1));
    last_t  = (ix_r == 3'(TAPS - 1)) && (jy_r == 3'(TAPS - 1));
    fr      = axis_r ? sy_r[15:0] : sx_r[15:0];
    dlt     = $signed({1'b0, tap_r, 16'b0}) - 20'sd131072 - $signed({4'b0, fr});
    tcur    = (dlt < 0) ? 18'(-dlt) : 18'(dlt);
    kill    = tcur[17];
    w_eff   = ({4'b0, width_r} < 13'(MAX_WIDTH)) ? {4'b0, width_r} : 13'(MAX_WIDTH);
    h_eff   = ({4'b0, height_r} < 13'(MAX_HEIGHT)) ? {4'b0, height_r} : 13'(MAX_HEIGHT);
    xs      = $signed({2'b0, sx_r[35:16]}) + $signed({19'b0, ix_r}) - 22'sd2;
    ys      = $signed({2'b0, sy_r[35:16]}) + $signed({19'b0, jy_r}) - 22'sd2;
    inb     = (xs >= 0) && (xs < $signed({9'b0, w_eff})) &&
              (ys >= 0) && (ys < $signed({9'b0, h_eff}));
    hstep   = $signed(prod[16 +: KW]) + kcoef(cb_r, cc_r, seg_r, 2'd2 - step_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && in_tuser[0]) state_nxt = S_MAPX;
      S_MAPX:   state_nxt = S_MAPY;
      S_MAPY:   state_nxt = S_MAPW;
      S_MAPW:   state_nxt = S_KSET;
      S_KSET:   state_nxt = kill ? (last_k ? S_TCHK : S_KSET) : S_KMUL;
      S_KMUL:   state_nxt = S_KADD;
      S_KADD:   state_nxt = (step_r == 2'd2) ? (last_k ? S_TCHK : S_KSET) : S_KMUL;
      S_TCHK:   state_nxt = inb ? S_TWT : (last_t ? S_DIV : S_TCHK);
      S_TWT:    state_nxt = S_TCH;
      S_TCH:    state_nxt = S_TACC;
      S_TACC:   state_nxt = last_t ? S_DIV : S_TCHK;
      S_DIV:    state_nxt = (wsum_r == '0) ? S_OUT : S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_res.done) state_nxt = (ch_r == CHW'(CHANNELS - 1)) ? S_OUT : S_DSTART;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = state_r == S_IDLE;
    div_start = state_r == S_DSTART;
    st_we     = (state_r == S_IDLE) && accept && !in_tuser[0] && load_ok;
    st_waddr  = AW'(in_tdata[12 +: YW]) * AW'(MAX_WIDTH) + AW'(in_tdata[0 +: XW]);
    st_raddr  = AW'(ys[YW-1:0]) * AW'(MAX_WIDTH) + AW'(xs[XW-1:0]);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_MAPX: begin
        mul_a = MW'({4'b0, col_r});
        mul_b = MW'({1'b0, isx_r});
      end
      S_MAPY: begin
        mul_a = MW'({4'b0, row_r});
        mul_b = MW'({1'b0, isy_r});
      end
      S_KMUL: begin
        mul_a = MW'(p_r);
        mul_b = MW'({1'b0, t_r});
      end
      S_TCHK: begin
        mul_a = MW'(kx_r[ix_r]);
        mul_b = MW'(ky_r[jy_r]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      tap_r       <= '0;
      step_r      <= '0;
      ix_r        <= '0;
      jy_r        <= '0;
      ch_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_MAPX: begin
          axis_r <= 1'b0;
          tap_r  <= '0;
        end
        S_KSET: begin
          step_r <= '0;
          if (kill) begin
            tap_r <= (tap_r == 3'(TAPS - 1)) ? 3'd0 : tap_r + 3'd1;
            if (tap_r == 3'(TAPS - 1)) axis_r <= 1'b1;
          end
        end
        S_KADD: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            tap_r <= (tap_r == 3'(TAPS - 1)) ? 3'd0 : tap_r + 3'd1;
            if (tap_r == 3'(TAPS - 1)) axis_r <= 1'b1;
          end
        end
        S_TCHK, S_TACC: begin
          if ((state_r == S_TACC) || !inb) begin
            // advance across the window, row by row
            ix_r <= (ix_r == 3'(TAPS - 1)) ? 3'd0 : ix_r + 3'd1;
            if (ix_r == 3'(TAPS - 1)) jy_r <= (jy_r == 3'(TAPS - 1)) ? 3'd0 : jy_r + 3'd1;
          end
        end
        S_DIV: ch_r <= '0;
        S_DWAIT: if (div_res.done) ch_r <= ch_r + CHW'(1);
        default: begin
        end
      endcase
    end
  end

  logic [31:0] res_pack;
  for (genvar gk = 0; gk < CHN_MAX; gk++) begin : g_pack
    if (gk < CHANNELS) begin : g_on
      assign res_pack[8*gk +: 8] = (wsum_r == '0) ? 8'd0 : q_r[gk];
    end else begin : g_off
      assign res_pack[8*gk +: 8] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        col_r <= in_tdata[11:0];
        row_r <= in_tdata[23:12];
      end
      S_MAPX: begin
        wsum_r <= '0;
        for (int k = 0; k < CHANNELS; k++) sum_r[k] <= '0;
      end
      S_MAPY: sx_r <= prod[35:0];
      S_MAPW: sy_r <= prod[35:0];
      S_KSET: begin
        t_r   <= tcur[TW-1:0];
        seg_r <= tcur[16];
        p_r   <= kcoef(cb_r, cc_r, tcur[16], 2'd3);
        if (kill) begin
          if (axis_r) ky_r[tap_r] <= '0;
          else        kx_r[tap_r] <= '0;
        end
      end
      S_KADD: begin
        p_r <= hstep;
        if (step_r == 2'd2) begin
          if (axis_r) ky_r[tap_r] <= hstep;
          else        kx_r[tap_r] <= hstep;
        end
      end
      S_TWT: begin
        wt_r <= $signed(prod[47:12]);
        px_r <= st_rdata;
      end
      S_TCH: begin
        for (int k = 0; k < CHANNELS; k++) begin
          chp_r[k] <= CPW'($signed({1'b0, px_r[8*k +: 8]}) * wt_r);
        end
      end
      S_TACC: begin
        wsum_r <= wsum_r + WSW'(wt_r);
        for (int k = 0; k < CHANNELS; k++) sum_r[k] <= sum_r[k] + SW'(chp_r[k]);
      end
      S_DWAIT: if (div_res.done) q_r[ch_r] <= div_res.quo;
      S_OUT: begin
        if (out_free) begin
          out_data_r  <= res_pack;
          out_empty_r <= wsum_r == '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_empty_r;

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DWAIT))
    else $error("divider finished while sequencer not waiting");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 32'd0))
    else $error("empty window with non-zero channels");

endmodule
`default_nettype wire

// ===== rtl/core/bsr_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on bsr_pkg for operand widths.
`default_nettype none
module bsr_mul (
  input  wire logic                         clk,
  input  wire logic signed [bsr_pkg::MW-1:0]  op_a,
  input  wire logic signed [bsr_pkg::MW-1:0]  op_b,
  output logic signed [bsr_pkg::PRW-1:0]      prod_r
);
  import bsr_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsr_store.sv =====
// Source pixel memory: one write port, one read port with registered data.
// No package dependency.
`default_nettype none
module bsr_store #(
  parameter int DEPTH = 65536,
  parameter int PW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [PW-1:0]            wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [PW-1:0]                 rd_data_r
);

  logic [PW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsr_div.sv =====
// Restoring divider giving s/d rounded half up, clamped to 0..255, one bit a cycle.
// Depends on bsr_pkg for widths, state encoding and the result struct.
`default_nettype none
module bsr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [bsr_pkg::SW-1:0]  num,
  input  wire logic signed [bsr_pkg::WSW-1:0] den,
  output bsr_pkg::bsr_div_res_t              res
);
  import bsr_pkg::*;

  bsr_dv_state_t       state_r, state_nxt;
  logic signed [DVW-1:0] n_r;
  logic [DDW-1:0]        dd_r;
  logic [DVW-1:0]        rem_r;
  logic [DVW-1:0]        dsh_r;
  logic [2:0]            cnt_r;
  logic [7:0]            q_r;

  logic signed [DVW-1:0] s_abs, d_abs;
  logic                  n_neg, n_big, ge;

  always_comb begin
    s_abs = (den < 0) ? -DVW'(num) : DVW'(num);
    d_abs = (den < 0) ? -DVW'(den) : DVW'(den);
    n_neg = n_r < 0;
    n_big = DVW'(n_r) >= (DVW'(dd_r) << 8);
    ge    = rem_r >= dsh_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = DV_PREP;
      DV_PREP: state_nxt = (n_neg || n_big) ? DV_DONE : DV_ITER;
      DV_ITER: if (cnt_r == 3'd0) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    res.done = state_r == DV_DONE;
    res.quo  = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        n_r  <= (s_abs <<< 1) + d_abs;
        dd_r <= DDW'(d_abs <<< 1);
      end
      DV_PREP: begin
        q_r   <= n_neg ? 8'd0 : (n_big ? 8'd255 : 8'd0);
        rem_r <= DVW'(n_r);
        dsh_r <= DVW'(dd_r) << 7;
        cnt_r <= 3'd7;
      end
      DV_ITER: begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[6:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 3'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the BC-spline image resampler.
// Predicts each compute result from its own pixel store and register copy.
// Depends on bsr_pkg and bc_spline_image_resampler_top.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bsr_pkg::*;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam int Q16 = 65536;

  typedef struct packed {
    logic [7:0] c3, c2, c1, c0;
    logic       empty;
  } pix_res_t;

  typedef struct {
    logic        op;
    logic [11:0] col, row;
    logic [7:0]  ch [4];
  } pix_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, out_tready = 1'b0, cfg_valid = 1'b0;
  logic [55:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [31:0] out_tdata;
  logic [0:0] out_tuser;

  bc_spline_image_resampler_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] pix_mem [int];
  int unsigned m_w, m_h, m_isx, m_isy;
  longint m_b, m_c;
  pix_res_t pending_res [$];
  int n_fail = 0, n_res = 0, n_load = 0, n_comp = 0, n_empty = 0;
  bit hold_out = 1'b0;
  // valid stays up after a handshake until the sender next waits
  bit in_held = 1'b0, cfg_held = 1'b0;

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint kern(longint t);
    longint p;
    if (t < Q16) begin
      p = 12 * ONE_Q12 - 9 * m_b - 6 * m_c;
      p = fl_shift(p * t, 16) + (-18 * ONE_Q12 + 12 * m_b + 6 * m_c);
      p = fl_shift(p * t, 16);
      p = fl_shift(p * t, 16) + (6 * ONE_Q12 - 2 * m_b);
      return p;
    end
    if (t < 2 * Q16) begin
      p = -m_b - 6 * m_c;
      p = fl_shift(p * t, 16) + (6 * m_b + 30 * m_c);
      p = fl_shift(p * t, 16) + (-12 * m_b - 48 * m_c);
      p = fl_shift(p * t, 16) + (8 * m_b + 24 * m_c);
      return p;
    end
    return 0;
  endfunction

  function automatic pix_res_t resample(logic [11:0] col, logic [11:0] row);
    longint w, h, sx, sy, fx, fy, frx, fry, dx, dy, x, y, wt, wsum, s, d, q;
    longint kx [5], ky [5], acc [4];
    logic [31:0] px;
    logic [7:0] ch [4];
    pix_res_t r;
    w = (m_w < 256) ? m_w : 256;
    h = (m_h < 256) ? m_h : 256;
    sx = longint'(col) * m_isx;
    sy = longint'(row) * m_isy;
    fx = sx >>> 16; fy = sy >>> 16;
    frx = sx & 16'hFFFF; fry = sy & 16'hFFFF;
    wsum = 0;
    for (int k = 0; k < 4; k++) acc[k] = 0;
    for (int i = 0; i < 5; i++) begin
      dx = longint'(i - 2) * Q16 - frx;
      dy = longint'(i - 2) * Q16 - fry;
      kx[i] = kern(dx < 0 ? -dx : dx);
      ky[i] = kern(dy < 0 ? -dy : dy);
    end
    for (int j = 0; j < 5; j++) begin
      y = fy + j - 2;
      if (y < 0 || y >= h) continue;
      for (int i = 0; i < 5; i++) begin
        x = fx + i - 2;
        if (x < 0 || x >= w) continue;
        px = pix_mem.exists(int'(y * 256 + x)) ? pix_mem[int'(y * 256 + x)] : '0;
        wt = fl_shift(kx[i] * ky[j], 12);
        wsum += wt;
        for (int k = 0; k < 4; k++) acc[k] += longint'(px[8*k +: 8]) * wt;
      end
    end
    r = '0;
    if (wsum == 0) begin
      r.empty = 1'b1;
      return r;
    end
    for (int k = 0; k < 4; k++) begin
      s = acc[k]; d = wsum;
      if (d < 0) begin
        s = -s; d = -d;
      end
      q = (2 * s + d) / (2 * d);
      if ((2 * s + d) % (2 * d) != 0 && (2 * s + d) < 0) q--;
      ch[k] = (q < 0) ? 8'd0 : (q > 255) ? 8'd255 : q[7:0];
    end
    r.c0 = ch[0]; r.c1 = ch[1]; r.c2 = ch[2]; r.c3 = ch[3];
    return r;
  endfunction

  // Whole window written? Reads of unwritten entries must never happen.
  function automatic bit window_loaded(logic [11:0] col, logic [11:0] row);
    longint w, h, fx, fy, x, y;
    w = (m_w < 256) ? m_w : 256;
    h = (m_h < 256) ? m_h : 256;
    fx = (longint'(col) * m_isx) >>> 16;
    fy = (longint'(row) * m_isy) >>> 16;
    for (int j = -2; j <= 2; j++)
      for (int i = -2; i <= 2; i++) begin
        x = fx + i; y = fy + j;
        if (x >= 0 && x < w && y >= 0 && y < h && !pix_mem.exists(int'(y * 256 + x)))
          return 1'b0;
      end
    return 1'b1;
  endfunction

  task automatic drop_in();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  task automatic drop_cfg();
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      drop_in();
      drop_cfg();
    end
    repeat (g) @(posedge clk);
  endtask

  task automatic send_item(pix_item_t it);
    drop_cfg();
    in_tuser <= it.op;
    in_tdata <= {it.ch[3], it.ch[2], it.ch[1], it.ch[0], it.row, it.col};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_held = 1'b1;
    if (it.op == OP_LOAD) begin
      n_load++;
      if (it.col < 256 && it.row < 256)
        pix_mem[it.row * 256 + it.col] = {it.ch[3], it.ch[2], it.ch[1], it.ch[0]};
    end else begin
      n_comp++;
      pending_res.push_back(resample(it.col, it.row));
    end
  endtask

  task automatic load_px(int c, int r, bit rnd);
    pix_item_t it;
    it.op = OP_LOAD; it.col = 12'(c); it.row = 12'(r);
    for (int k = 0; k < 4; k++) it.ch[k] = rnd ? 8'($urandom) : 8'(c * 7 + r * 13 + k * 50);
    send_item(it);
  endtask

  task automatic compute_px(int c, int r);
    pix_item_t it;
    it.op = OP_COMPUTE; it.col = 12'(c); it.row = 12'(r);
    for (int k = 0; k < 4; k++) it.ch[k] = 8'($urandom);
    send_item(it);
  endtask

  task automatic drain();
    drop_in();
    drop_cfg();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(bsr_cfg_idx_t idx, logic [23:0] val);
    drop_in();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_held = 1'b1;
    case (idx)
      CFG_SRC_WIDTH:   m_w = val[8:0];
      CFG_SRC_HEIGHT:  m_h = val[8:0];
      CFG_INV_SCALE_X: m_isx = val;
      CFG_INV_SCALE_Y: m_isy = val;
      CFG_COEF_B:      m_b = longint'(signed'(val[15:0]));
      CFG_COEF_C:      m_c = longint'(signed'(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic set_all(int w, int h, int isx, int isy, int b, int c);
    write_reg(CFG_SRC_WIDTH, 24'(w));
    write_reg(CFG_SRC_HEIGHT, 24'(h));
    write_reg(CFG_INV_SCALE_X, 24'(isx));
    write_reg(CFG_INV_SCALE_Y, 24'(isy));
    write_reg(CFG_COEF_B, 24'(b));
    write_reg(CFG_COEF_C, 24'(c));
  endtask

  // result checker
  always @(posedge clk) begin
    pix_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:24], out_tdata[23:16], out_tdata[15:8], out_tdata[7:0], out_tuser[0]};
      n_res++;
      if (got.empty) n_empty++;
      if (pending_res.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got != want) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: ch %h %h %h %h empty %b, expected %h %h %h %h empty %b",
                     got.c0, got.c1, got.c2, got.c3, got.empty,
                     want.c0, want.c1, want.c2, want.c3, want.empty);
        end
      end
    end
  end

  // receiver with random stalls; hold_out forces a long back-pressure stretch
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        for (int n = 0; n < 3000; n++) @(posedge clk);
        hold_out = 1'b0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    #80ms;
    $display("RESULT: ERROR");
    $finish;
  end

  typedef struct {
    int col, row;
    bit has_res;
    pix_res_t res;
  } dir_row_t;

  initial begin
    dir_row_t dir [$];
    int n, c, r, bw, bh;
    m_w = 256; m_h = 256; m_isx = Q16; m_isy = Q16; m_b = 1365; m_c = 1365;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 12x12 patch of pixels, reset configuration
    for (r = 0; r < 12; r++)
      for (c = 0; c < 12; c++) load_px(c, r, 1'b0);
    load_px(4095, 4095, 1'b1);    // load outside the store: ignored
    load_px(300, 2, 1'b1);
    dir = '{
      '{0, 0, 1'b0, '0}, '{5, 5, 1'b0, '0}, '{9, 0, 1'b0, '0}, '{3, 9, 1'b0, '0},
      '{4095, 4095, 1'b1, 33'h1}, '{300, 5, 1'b1, 33'h1}, '{5, 300, 1'b1, 33'h1}};
    foreach (dir[i]) begin
      compute_px(dir[i].col, dir[i].row);
      if (dir[i].has_res && pending_res[$] != dir[i].res) begin
        n_fail++;
        $display("predictor disagrees with table row %0d", i);
      end
    end
    drain();

    // extremes of the registers
    set_all(12, 12, 0, 0, -32768, 32767);
    compute_px(4095, 4095);
    compute_px(7, 1);
    drain();
    set_all(0, 12, Q16, Q16, 1365, 1365);
    compute_px(3, 3);
    drain();
    set_all(511, 12, 24'hFFFFFF, 1, 32767, -32768);
    compute_px(0, 5);
    compute_px(0, 4095);
    drain();
    set_all(12, 12, 24'h008000, 24'h018000, 0, 8192);
    compute_px(9, 6);
    drain();

    // random phases: load pixels of a random image, then computes, mostly at small coordinates
    for (int ph = 0; ph < 8; ph++) begin
      bw = $urandom_range(1, 16); bh = $urandom_range(1, 16);
      if (ph == 7) begin
        bw = 256; bh = 256;
      end
      set_all(bw, bh, $urandom_range(1, 3 * Q16), $urandom_range(1, 3 * Q16),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      if (ph == 3) write_reg(CFG_COEF_B, 24'h008000);
      if (ph == 7) begin
        write_reg(CFG_INV_SCALE_X, Q16);
        write_reg(CFG_INV_SCALE_Y, Q16);
      end
      for (r = 0; r < ((ph == 7) ? 10 : bh); r++)
        for (c = 0; c < ((ph == 7) ? 10 : bw); c++)
          if (r >= 12 || c >= 12 || $urandom_range(0, 3) == 0) begin
            load_px(c, r, 1'b1);
            if ($urandom_range(0, 3) == 0) random_gap();
          end
      if (ph == 2) hold_out = 1'b1;
      n = 0;
      while (n < 30) begin
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
        if (ph == 7 && $urandom_range(0, 3) != 0) begin
          c = $urandom_range(0, 7); r = $urandom_range(0, 7);
          if ($urandom_range(0, 1)) begin
            c = 4095; r = 4095;
          end
        end
        if (window_loaded(c, r)) begin
          compute_px(c, r);
          n++;
        end else if ($urandom_range(0, 7) == 0) begin
          load_px($urandom_range(256, 4095), $urandom_range(0, 4095), 1'b1);
        end
        if (ph == 4 && n == 15) begin
          drop_in();
          drop_cfg();
          while (pending_res.size() != 0) @(posedge clk);
        end
        random_gap();
      end
      drain();
    end

    $display("covered %0d loads, %0d computes, %0d results (%0d empty windows)",
             n_load, n_comp, n_res, n_empty);
    if (n_fail == 0 && pending_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d results outstanding", n_fail, pending_res.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/bsr_pkg.sv
rtl/core/bsr_mul.sv
rtl/core/bsr_store.sv
rtl/core/bsr_div.sv
rtl/core/bc_spline_image_resampler_top.sv
tb/sv/testbench.sv
